/* rtl/cpu6502_execute_unit_defines.svh */
// Assertion macros for the 6502 execute unit.
// Needs clk_i and rst_ni in the scope that expands them.
`ifndef CPU6502_EXECUTE_UNIT_DEFINES_SVH
`define CPU6502_EXECUTE_UNIT_DEFINES_SVH

// Implication checked on every rising edge, off while reset is held.
`define C6502EU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Signal free of X and Z whenever the enable holds, off while reset is held.
`define C6502EU_ASSERT_KNOWN(label, en, sig, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (en) |-> !$isunknown(sig)) \
    else $error(msg);

`endif

/* rtl/c6502eu_pkg.sv */
// Shared types and constants for the 6502 execute unit.
// No dependencies; imported by the decoder, the ALU and the top level.
package c6502eu_pkg;

  localparam logic [7:0] SpReset = 8'hfd;

  typedef enum logic [5:0] {
    OP_NOP, OP_ORA, OP_AND, OP_EOR, OP_ADC, OP_SBC,
    OP_CMP, OP_CPX, OP_CPY, OP_BIT,
    OP_SHIFT_A, OP_SHIFT_M, OP_DEC_M, OP_INC_M,
    OP_LDA, OP_LDX, OP_LDY, OP_STA, OP_STX, OP_STY,
    OP_TAX, OP_TAY, OP_TSX, OP_TXA, OP_TYA, OP_TXS,
    OP_INX, OP_INY, OP_DEX, OP_DEY,
    OP_CLC, OP_SEC, OP_CLI, OP_SEI, OP_CLV, OP_CLD, OP_SED
  } op_e;

  // Matches opcode bits [6:5] of the shift/rotate group.
  typedef enum logic [1:0] {
    SH_ASL = 2'd0,
    SH_ROL = 2'd1,
    SH_LSR = 2'd2,
    SH_ROR = 2'd3
  } shift_e;

  typedef struct packed {
    op_e    op;
    shift_e shift;
  } dec_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic       n;
    logic       v;
    logic       d;
    logic       i;
    logic       z;
    logic       c;
  } regs_t;

endpackage

/* rtl/c6502eu_decode.sv */
// Opcode decoder: maps a 6502 opcode byte to an operation class.
// Depends on c6502eu_pkg.
module c6502eu_decode import c6502eu_pkg::*; (
  input  logic [7:0] opcode_i,
  output dec_t       dec_o
);

  always_comb begin
    dec_o.shift = shift_e'(opcode_i[6:5]);
    unique case (opcode_i)
      8'h01, 8'h05, 8'h09, 8'h0d, 8'h11, 8'h15, 8'h19, 8'h1d: dec_o.op = OP_ORA;
      8'h21, 8'h25, 8'h29, 8'h2d, 8'h31, 8'h35, 8'h39, 8'h3d: dec_o.op = OP_AND;
      8'h41, 8'h45, 8'h49, 8'h4d, 8'h51, 8'h55, 8'h59, 8'h5d: dec_o.op = OP_EOR;
      8'h61, 8'h65, 8'h69, 8'h6d, 8'h71, 8'h75, 8'h79, 8'h7d: dec_o.op = OP_ADC;
      8'he1, 8'he5, 8'he9, 8'hed, 8'hf1, 8'hf5, 8'hf9, 8'hfd: dec_o.op = OP_SBC;
      8'hc1, 8'hc5, 8'hc9, 8'hcd, 8'hd1, 8'hd5, 8'hd9, 8'hdd: dec_o.op = OP_CMP;
      8'he0, 8'he4, 8'hec:                                     dec_o.op = OP_CPX;
      8'hc0, 8'hc4, 8'hcc:                                     dec_o.op = OP_CPY;
      8'h24, 8'h2c:                                            dec_o.op = OP_BIT;
      8'h0a, 8'h2a, 8'h4a, 8'h6a:                              dec_o.op = OP_SHIFT_A;
      8'h06, 8'h0e, 8'h16, 8'h1e, 8'h26, 8'h2e, 8'h36, 8'h3e,
      8'h46, 8'h4e, 8'h56, 8'h5e, 8'h66, 8'h6e, 8'h76, 8'h7e: dec_o.op = OP_SHIFT_M;
      8'hc6, 8'hce, 8'hd6, 8'hde:                              dec_o.op = OP_DEC_M;
      8'he6, 8'hee, 8'hf6, 8'hfe:                              dec_o.op = OP_INC_M;
      8'ha1, 8'ha5, 8'ha9, 8'had, 8'hb1, 8'hb5, 8'hb9, 8'hbd: dec_o.op = OP_LDA;
      8'ha2, 8'ha6, 8'hae, 8'hb6, 8'hbe:                       dec_o.op = OP_LDX;
      8'ha0, 8'ha4, 8'hac, 8'hb4, 8'hbc:                       dec_o.op = OP_LDY;
      8'h81, 8'h85, 8'h8d, 8'h91, 8'h95, 8'h99, 8'h9d:         dec_o.op = OP_STA;
      8'h86, 8'h8e, 8'h96:                                     dec_o.op = OP_STX;
      8'h84, 8'h8c, 8'h94:                                     dec_o.op = OP_STY;
      8'haa: dec_o.op = OP_TAX;
      8'ha8: dec_o.op = OP_TAY;
      8'hba: dec_o.op = OP_TSX;
      8'h8a: dec_o.op = OP_TXA;
      8'h98: dec_o.op = OP_TYA;
      8'h9a: dec_o.op = OP_TXS;
      8'he8: dec_o.op = OP_INX;
      8'hc8: dec_o.op = OP_INY;
      8'hca: dec_o.op = OP_DEX;
      8'h88: dec_o.op = OP_DEY;
      8'h18: dec_o.op = OP_CLC;
      8'h38: dec_o.op = OP_SEC;
      8'h58: dec_o.op = OP_CLI;
      8'h78: dec_o.op = OP_SEI;
      8'hb8: dec_o.op = OP_CLV;
      8'hd8: dec_o.op = OP_CLD;
      8'hf8: dec_o.op = OP_SED;
      default: dec_o.op = OP_NOP;  // unofficial, control flow, stack, NOP
    endcase
  end

endmodule

/* rtl/c6502eu_alu.sv */
// Combinational datapath: one 6502 data operation on the register file.
// Depends on c6502eu_pkg.
module c6502eu_alu import c6502eu_pkg::*; (
  input  dec_t       dec_i,
  input  logic [7:0] operand_i,
  input  regs_t      regs_i,
  output regs_t      regs_o,
  output logic       mem_write_o,
  output logic [7:0] write_data_o
);

  logic [7:0] add_a;
  logic [7:0] add_b;
  logic       add_ci;
  logic [8:0] sum;
  logic [7:0] sh_in;
  logic [7:0] sh_out;
  logic       sh_c;
  logic [7:0] nz_val;
  logic       nz_en;

  // Shared adder: ADC, SBC (inverted operand) and compares (r + ~m + 1).
  always_comb begin
    add_a  = regs_i.a;
    add_b  = operand_i;
    add_ci = regs_i.c;
    unique case (dec_i.op)
      OP_SBC: add_b = ~operand_i;
      OP_CMP: begin add_b = ~operand_i; add_ci = 1'b1; end
      OP_CPX: begin add_a = regs_i.x; add_b = ~operand_i; add_ci = 1'b1; end
      OP_CPY: begin add_a = regs_i.y; add_b = ~operand_i; add_ci = 1'b1; end
      default: ;
    endcase
    sum = {1'b0, add_a} + {1'b0, add_b} + {8'd0, add_ci};
  end

  always_comb begin
    sh_in = (dec_i.op == OP_SHIFT_A) ? regs_i.a : operand_i;
    unique case (dec_i.shift)
      SH_ASL: begin sh_out = {sh_in[6:0], 1'b0};     sh_c = sh_in[7]; end
      SH_ROL: begin sh_out = {sh_in[6:0], regs_i.c}; sh_c = sh_in[7]; end
      SH_LSR: begin sh_out = {1'b0, sh_in[7:1]};     sh_c = sh_in[0]; end
      SH_ROR: begin sh_out = {regs_i.c, sh_in[7:1]}; sh_c = sh_in[0]; end
      default: begin sh_out = sh_in; sh_c = regs_i.c; end
    endcase
  end

  always_comb begin
    regs_o       = regs_i;
    mem_write_o  = 1'b0;
    write_data_o = 8'd0;
    nz_val       = 8'd0;
    nz_en        = 1'b1;
    unique case (dec_i.op)
      OP_ORA: begin nz_val = regs_i.a | operand_i; regs_o.a = nz_val; end
      OP_AND: begin nz_val = regs_i.a & operand_i; regs_o.a = nz_val; end
      OP_EOR: begin nz_val = regs_i.a ^ operand_i; regs_o.a = nz_val; end
      OP_ADC, OP_SBC: begin
        nz_val   = sum[7:0];
        regs_o.a = nz_val;
        regs_o.c = sum[8];
        regs_o.v = ~(regs_i.a[7] ^ add_b[7]) & (regs_i.a[7] ^ sum[7]);
      end
      OP_CMP, OP_CPX, OP_CPY: begin
        nz_val   = sum[7:0];
        regs_o.c = sum[8];
      end
      OP_BIT: begin
        nz_en    = 1'b0;
        regs_o.n = operand_i[7];
        regs_o.v = operand_i[6];
        regs_o.z = ((operand_i & regs_i.a) == 8'd0);
      end
      OP_SHIFT_A: begin nz_val = sh_out; regs_o.a = sh_out; regs_o.c = sh_c; end
      OP_SHIFT_M: begin
        nz_val = sh_out; regs_o.c = sh_c;
        mem_write_o = 1'b1; write_data_o = sh_out;
      end
      OP_DEC_M: begin
        nz_val = operand_i - 8'd1; mem_write_o = 1'b1; write_data_o = nz_val;
      end
      OP_INC_M: begin
        nz_val = operand_i + 8'd1; mem_write_o = 1'b1; write_data_o = nz_val;
      end
      OP_LDA: begin nz_val = operand_i; regs_o.a = nz_val; end
      OP_LDX: begin nz_val = operand_i; regs_o.x = nz_val; end
      OP_LDY: begin nz_val = operand_i; regs_o.y = nz_val; end
      OP_STA: begin nz_en = 1'b0; mem_write_o = 1'b1; write_data_o = regs_i.a; end
      OP_STX: begin nz_en = 1'b0; mem_write_o = 1'b1; write_data_o = regs_i.x; end
      OP_STY: begin nz_en = 1'b0; mem_write_o = 1'b1; write_data_o = regs_i.y; end
      OP_TAX: begin nz_val = regs_i.a;  regs_o.x = nz_val; end
      OP_TAY: begin nz_val = regs_i.a;  regs_o.y = nz_val; end
      OP_TSX: begin nz_val = regs_i.sp; regs_o.x = nz_val; end
      OP_TXA: begin nz_val = regs_i.x;  regs_o.a = nz_val; end
      OP_TYA: begin nz_val = regs_i.y;  regs_o.a = nz_val; end
      OP_TXS: begin nz_en = 1'b0; regs_o.sp = regs_i.x; end  // flags untouched
      OP_INX: begin nz_val = regs_i.x + 8'd1; regs_o.x = nz_val; end
      OP_INY: begin nz_val = regs_i.y + 8'd1; regs_o.y = nz_val; end
      OP_DEX: begin nz_val = regs_i.x - 8'd1; regs_o.x = nz_val; end
      OP_DEY: begin nz_val = regs_i.y - 8'd1; regs_o.y = nz_val; end
      OP_CLC: begin nz_en = 1'b0; regs_o.c = 1'b0; end
      OP_SEC: begin nz_en = 1'b0; regs_o.c = 1'b1; end
      OP_CLI: begin nz_en = 1'b0; regs_o.i = 1'b0; end
      OP_SEI: begin nz_en = 1'b0; regs_o.i = 1'b1; end
      OP_CLV: begin nz_en = 1'b0; regs_o.v = 1'b0; end
      OP_CLD: begin nz_en = 1'b0; regs_o.d = 1'b0; end
      OP_SED: begin nz_en = 1'b0; regs_o.d = 1'b1; end
      default: nz_en = 1'b0;  // OP_NOP
    endcase
    if (nz_en) begin
      regs_o.n = nz_val[7];
      regs_o.z = (nz_val == 8'd0);
    end
  end

endmodule

/* rtl/cpu6502_execute_unit.sv */
// Channel  | Dir | Bus fields (low bit up)                          | Beat
// s_axis   | in  | tuser: req_type[7:0]; tdata: operand[7:0]          | one instruction
// m_axis   | out | tuser: mem_write; tdata: write_data, acc, x, y,    | one result
//          |     |   sp, status (N V 0 0 D I Z C) at 8 bits each      |
//
// Two register stages: the input register holds the decoded opcode and the
// operand, the ALU sits between it and the result register. One instruction
// per cycle sustained while the output is not stalled; an instruction moves
// from the input register to the result register. The register file (A, X,
// Y, SP, flags) updates when an instruction moves into the result register,
// so back-to-back dependent instructions see it. rst_ni (async, low) clears
// A, X, Y and flags, sets SP to 0xfd, empties both stages. A stalled output
// holds its beat; input keeps flowing until both stages are full.
// Depends on c6502eu_pkg, c6502eu_decode, c6502eu_alu and the defines header.
`include "cpu6502_execute_unit_defines.svh"

module cpu6502_execute_unit import c6502eu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // operand[7:0]
  input  logic [7:0]  s_axis_tuser,   // req_type[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // write_data[7:0], acc_out[15:8], x_out[23:16], y_out[31:24],
  // sp_out[39:32], status_out[47:40]
  output logic [47:0] m_axis_tdata,
  output logic [0:0]  m_axis_tuser    // mem_write[0]
);

  // Input stage
  logic       in_valid_q;
  dec_t       dec_d, dec_q;
  logic [7:0] operand_q;

  // Architectural registers
  regs_t      regs_q, regs_d;

  // Result stage
  logic       out_valid_q;
  logic       mem_write_d, mem_write_q;
  logic [7:0] write_data_d, write_data_q;
  regs_t      res_regs_q;

  logic       advance;   // input-stage instruction retires this edge
  logic       in_take;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  c6502eu_decode u_decode (
    .opcode_i (s_axis_tuser),
    .dec_o    (dec_d)
  );

  c6502eu_alu u_alu (
    .dec_i        (dec_q),
    .operand_i    (operand_q),
    .regs_i       (regs_q),
    .regs_o       (regs_d),
    .mem_write_o  (mem_write_d),
    .write_data_o (write_data_d)
  );

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Register file commits as the instruction retires
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= '{a: 8'd0, x: 8'd0, y: 8'd0, sp: SpReset,
                  n: 1'b0, v: 1'b0, d: 1'b0, i: 1'b0, z: 1'b0, c: 1'b0};
    end else if (advance) begin
      regs_q <= regs_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      dec_q     <= dec_d;
      operand_q <= s_axis_tdata;
    end
    if (advance) begin
      mem_write_q  <= mem_write_d;
      write_data_q <= write_data_d;
      res_regs_q   <= regs_d;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tuser[0] = mem_write_q;
  assign m_axis_tdata    = {res_regs_q.n, res_regs_q.v, 2'b00,
                            res_regs_q.d, res_regs_q.i, res_regs_q.z, res_regs_q.c,
                            res_regs_q.sp, res_regs_q.y, res_regs_q.x, res_regs_q.a,
                            write_data_q};

  // Register file only moves when an instruction retires.
  `C6502EU_ASSERT(a_regs_hold, !advance |=> $stable(regs_q), "register file moved without retire")
  // A pending result always shows the current register file.
  `C6502EU_ASSERT(a_res_matches, out_valid_q |-> (res_regs_q == regs_q), "result differs from regs")
  // A retiring instruction always lands in the result stage.
  `C6502EU_ASSERT(a_retire_lands, advance |=> out_valid_q, "retired instruction lost")
  // A valid result beat carries no unknown bits.
  `C6502EU_ASSERT_KNOWN(a_out_known, m_axis_tvalid, m_axis_tdata, "result beat has unknown bits")

endmodule

/* tb/cpu6502_execute_unit_tb.sv */
// Self-checking bench for cpu6502_execute_unit: drives opcode/operand beats
// and checks every result beat against an in-bench model of the register file.
// Depends on c6502eu_pkg (op_e, shift_e, dec_t, regs_t, SpReset).
`timescale 1ns / 1ps

module cpu6502_execute_unit_tb import c6502eu_pkg::*; ();

  localparam time ClkHalf = 4ns;

  // Opcodes named for the reset and unused-opcode checks.
  localparam logic [7:0] OpcNop      = 8'hea;
  localparam logic [7:0] OpcNopImm   = 8'h89;  // unofficial, no effect
  localparam logic [7:0] OpcSbcAlias = 8'heb;  // unofficial SBC alias, no effect
  localparam logic [7:0] OpcBrk      = 8'h00;
  localparam logic [7:0] OpcJmp      = 8'h4c;
  localparam logic [7:0] OpcPha      = 8'h48;
  localparam logic [7:0] OpcBpl      = 8'h10;

  typedef struct packed {
    logic       mem_write;
    logic [7:0] write_data;
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] status;
  } exec_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // operand[7:0]
  logic [7:0]  s_axis_tuser;   // req_type[7:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // write_data[7:0], acc[15:8], x[23:16], y[31:24], sp[39:32], status[47:40]
  logic [47:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;   // mem_write[0]

  regs_t          cpu_state;
  exec_result_t   pending_results[$];
  exec_result_t   seen_beat, want_beat;
  bit             no_idle = 1'b0;
  int unsigned    items_sent = 0;
  int unsigned    beats_seen = 0;
  int unsigned    mismatches = 0;

  always #(ClkHalf) clk_i = ~clk_i;

  cpu6502_execute_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // ---------------------------------------------------------------------------
  // Opcode map and execute model
  // ---------------------------------------------------------------------------

  // Everything outside the data-path set (undefined, branches, stack, NOP)
  // maps to OP_NOP.
  function automatic dec_t decode_opcode(logic [7:0] opc);
    dec_t d;
    d.shift = shift_e'(opc[6:5]);
    case (opc)
      8'h01, 8'h05, 8'h09, 8'h0d, 8'h11, 8'h15, 8'h19, 8'h1d: d.op = OP_ORA;
      8'h21, 8'h25, 8'h29, 8'h2d, 8'h31, 8'h35, 8'h39, 8'h3d: d.op = OP_AND;
      8'h41, 8'h45, 8'h49, 8'h4d, 8'h51, 8'h55, 8'h59, 8'h5d: d.op = OP_EOR;
      8'h61, 8'h65, 8'h69, 8'h6d, 8'h71, 8'h75, 8'h79, 8'h7d: d.op = OP_ADC;
      8'he1, 8'he5, 8'he9, 8'hed, 8'hf1, 8'hf5, 8'hf9, 8'hfd: d.op = OP_SBC;
      8'hc1, 8'hc5, 8'hc9, 8'hcd, 8'hd1, 8'hd5, 8'hd9, 8'hdd: d.op = OP_CMP;
      8'he0, 8'he4, 8'hec: d.op = OP_CPX;
      8'hc0, 8'hc4, 8'hcc: d.op = OP_CPY;
      8'h24, 8'h2c:        d.op = OP_BIT;
      8'h0a, 8'h2a, 8'h4a, 8'h6a: d.op = OP_SHIFT_A;
      8'h06, 8'h0e, 8'h16, 8'h1e, 8'h26, 8'h2e, 8'h36, 8'h3e,
      8'h46, 8'h4e, 8'h56, 8'h5e, 8'h66, 8'h6e, 8'h76, 8'h7e: d.op = OP_SHIFT_M;
      8'hc6, 8'hce, 8'hd6, 8'hde: d.op = OP_DEC_M;
      8'he6, 8'hee, 8'hf6, 8'hfe: d.op = OP_INC_M;
      8'ha1, 8'ha5, 8'ha9, 8'had, 8'hb1, 8'hb5, 8'hb9, 8'hbd: d.op = OP_LDA;
      8'ha2, 8'ha6, 8'hae, 8'hb6, 8'hbe: d.op = OP_LDX;
      8'ha0, 8'ha4, 8'hac, 8'hb4, 8'hbc: d.op = OP_LDY;
      8'h81, 8'h85, 8'h8d, 8'h91, 8'h95, 8'h99, 8'h9d: d.op = OP_STA;
      8'h86, 8'h8e, 8'h96: d.op = OP_STX;
      8'h84, 8'h8c, 8'h94: d.op = OP_STY;
      8'haa: d.op = OP_TAX;
      8'ha8: d.op = OP_TAY;
      8'hba: d.op = OP_TSX;
      8'h8a: d.op = OP_TXA;
      8'h98: d.op = OP_TYA;
      8'h9a: d.op = OP_TXS;
      8'he8: d.op = OP_INX;
      8'hc8: d.op = OP_INY;
      8'hca: d.op = OP_DEX;
      8'h88: d.op = OP_DEY;
      8'h18: d.op = OP_CLC;
      8'h38: d.op = OP_SEC;
      8'h58: d.op = OP_CLI;
      8'h78: d.op = OP_SEI;
      8'hb8: d.op = OP_CLV;
      8'hd8: d.op = OP_CLD;
      8'hf8: d.op = OP_SED;
      default: d.op = OP_NOP;
    endcase
    return d;
  endfunction

  function automatic logic [7:0] set_nz(logic [7:0] val);
    cpu_state.n = val[7];
    cpu_state.z = (val == 8'h00);
    return val;
  endfunction

  function automatic logic [7:0] shift_byte(shift_e kind, logic [7:0] val);
    logic       cin;
    logic [7:0] res;
    cin = cpu_state.c;
    case (kind)
      SH_ASL: begin cpu_state.c = val[7]; res = {val[6:0], 1'b0}; end
      SH_ROL: begin cpu_state.c = val[7]; res = {val[6:0], cin};  end
      SH_LSR: begin cpu_state.c = val[0]; res = {1'b0, val[7:1]}; end
      default: begin cpu_state.c = val[0]; res = {cin, val[7:1]}; end
    endcase
    return set_nz(res);
  endfunction

  function automatic void compare_to(logic [7:0] reg_val, logic [7:0] mem);
    cpu_state.c = (reg_val >= mem);
    void'(set_nz(reg_val - mem));
  endfunction

  // Binary add; SBC feeds the inverted operand. D never changes the math.
  function automatic void add_carry(logic [7:0] addend);
    logic [8:0] sum;
    sum = {1'b0, cpu_state.a} + {1'b0, addend} + {8'h00, cpu_state.c};
    cpu_state.c = sum[8];
    cpu_state.v = ~(cpu_state.a[7] ^ addend[7]) & (cpu_state.a[7] ^ sum[7]);
    cpu_state.a = set_nz(sum[7:0]);
  endfunction

  function automatic exec_result_t execute_instr(logic [7:0] opc, logic [7:0] mem);
    dec_t         d;
    exec_result_t r;
    d = decode_opcode(opc);
    r.mem_write  = 1'b0;
    r.write_data = 8'h00;
    case (d.op)
      OP_ORA: cpu_state.a = set_nz(cpu_state.a | mem);
      OP_AND: cpu_state.a = set_nz(cpu_state.a & mem);
      OP_EOR: cpu_state.a = set_nz(cpu_state.a ^ mem);
      OP_ADC: add_carry(mem);
      OP_SBC: add_carry(~mem);
      OP_CMP: compare_to(cpu_state.a, mem);
      OP_CPX: compare_to(cpu_state.x, mem);
      OP_CPY: compare_to(cpu_state.y, mem);
      OP_BIT: begin
        cpu_state.n = mem[7];
        cpu_state.v = mem[6];
        cpu_state.z = ((mem & cpu_state.a) == 8'h00);
      end
      OP_SHIFT_A: cpu_state.a = shift_byte(d.shift, cpu_state.a);
      OP_SHIFT_M: begin r.mem_write = 1'b1; r.write_data = shift_byte(d.shift, mem); end
      OP_DEC_M:   begin r.mem_write = 1'b1; r.write_data = set_nz(mem - 8'h01); end
      OP_INC_M:   begin r.mem_write = 1'b1; r.write_data = set_nz(mem + 8'h01); end
      OP_LDA: cpu_state.a = set_nz(mem);
      OP_LDX: cpu_state.x = set_nz(mem);
      OP_LDY: cpu_state.y = set_nz(mem);
      OP_STA: begin r.mem_write = 1'b1; r.write_data = cpu_state.a; end
      OP_STX: begin r.mem_write = 1'b1; r.write_data = cpu_state.x; end
      OP_STY: begin r.mem_write = 1'b1; r.write_data = cpu_state.y; end
      OP_TAX: cpu_state.x = set_nz(cpu_state.a);
      OP_TAY: cpu_state.y = set_nz(cpu_state.a);
      OP_TSX: cpu_state.x = set_nz(cpu_state.sp);
      OP_TXA: cpu_state.a = set_nz(cpu_state.x);
      OP_TYA: cpu_state.a = set_nz(cpu_state.y);
      OP_TXS: cpu_state.sp = cpu_state.x;  // flags untouched
      OP_INX: cpu_state.x = set_nz(cpu_state.x + 8'h01);
      OP_INY: cpu_state.y = set_nz(cpu_state.y + 8'h01);
      OP_DEX: cpu_state.x = set_nz(cpu_state.x - 8'h01);
      OP_DEY: cpu_state.y = set_nz(cpu_state.y - 8'h01);
      OP_CLC: cpu_state.c = 1'b0;
      OP_SEC: cpu_state.c = 1'b1;
      OP_CLI: cpu_state.i = 1'b0;
      OP_SEI: cpu_state.i = 1'b1;
      OP_CLV: cpu_state.v = 1'b0;
      OP_CLD: cpu_state.d = 1'b0;
      OP_SED: cpu_state.d = 1'b1;
      default: ;
    endcase
    r.acc    = cpu_state.a;
    r.x      = cpu_state.x;
    r.y      = cpu_state.y;
    r.sp     = cpu_state.sp;
    r.status = {cpu_state.n, cpu_state.v, 2'b00,
                cpu_state.d, cpu_state.i, cpu_state.z, cpu_state.c};
    return r;
  endfunction

  // Random opcode of the given class; the shift kind only matters for shifts.
  function automatic logic [7:0] pick_opcode(op_e op, shift_e kind = SH_ASL);
    logic [7:0] opc;
    dec_t       d;
    do begin
      opc = 8'($urandom_range(0, 255));
      d   = decode_opcode(opc);
    end while (d.op != op ||
               ((op == OP_SHIFT_A || op == OP_SHIFT_M) && d.shift != kind));
    return opc;
  endfunction

  function automatic logic [7:0] pick_operand();
    logic [7:0] corners[5] = '{8'h00, 8'h01, 8'h7f, 8'h80, 8'hff};
    if ($urandom_range(0, 3) == 0) return corners[3'($urandom_range(0, 4))];
    return 8'($urandom_range(0, 255));
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one beat per call, random gap before it
  // ---------------------------------------------------------------------------
  task automatic send_instr(input logic [7:0] opc, input logic [7:0] mem);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= opc;
    s_axis_tdata  <= mem;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(execute_instr(opc, mem));
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall before each beat
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 8);
      @(negedge clk_i);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %02h, got %02h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      beats_seen++;
      seen_beat = {m_axis_tuser[0], m_axis_tdata[7:0], m_axis_tdata[15:8],
                   m_axis_tdata[23:16], m_axis_tdata[31:24],
                   m_axis_tdata[39:32], m_axis_tdata[47:40]};
      if (pending_results.size() == 0) begin
        $error("result beat with nothing outstanding: %p", seen_beat);
        mismatches++;
      end else begin
        want_beat = pending_results.pop_front();
        check_field("mem_write", {7'd0, want_beat.mem_write}, {7'd0, seen_beat.mem_write});
        check_field("write_data", want_beat.write_data, seen_beat.write_data);
        check_field("acc_out", want_beat.acc, seen_beat.acc);
        check_field("x_out", want_beat.x, seen_beat.x);
        check_field("y_out", want_beat.y, seen_beat.y);
        check_field("sp_out", want_beat.sp, seen_beat.sp);
        check_field("status_out", want_beat.status, seen_beat.status);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // First beat after reset exposes the reset register file.
  task automatic test_reset_values();
    send_instr(OpcNop, 8'hff);
  endtask

  task automatic test_loads_stores();
    send_instr(pick_opcode(OP_LDA), 8'h80);
    send_instr(pick_opcode(OP_LDX), 8'hff);
    send_instr(pick_opcode(OP_LDY), 8'h00);
    send_instr(pick_opcode(OP_STA), 8'h5a);
    send_instr(pick_opcode(OP_STX), 8'ha5);
    send_instr(pick_opcode(OP_STY), 8'hff);
  endtask

  // Wrap of the index registers both ways, then every transfer incl. SP.
  task automatic test_transfers_and_steps();
    send_instr(pick_opcode(OP_INX), 8'h00);  // ff -> 00
    send_instr(pick_opcode(OP_DEY), 8'hff);  // 00 -> ff
    send_instr(pick_opcode(OP_INY), 8'h00);
    send_instr(pick_opcode(OP_DEX), 8'h00);
    send_instr(pick_opcode(OP_TSX), 8'h00);
    send_instr(pick_opcode(OP_TAY), 8'h00);
    send_instr(pick_opcode(OP_TXA), 8'h00);
    send_instr(pick_opcode(OP_TYA), 8'h00);
    send_instr(pick_opcode(OP_TAX), 8'h00);
    send_instr(pick_opcode(OP_TXS), 8'h00);
  endtask

  // Signed overflow both ways, carry out, and binary math with D set.
  task automatic test_arith();
    send_instr(pick_opcode(OP_LDA), 8'h7f);
    send_instr(pick_opcode(OP_ADC), 8'h01);
    send_instr(pick_opcode(OP_ADC), 8'hff);
    send_instr(pick_opcode(OP_SED), 8'h00);
    send_instr(pick_opcode(OP_SBC), 8'h80);
    send_instr(pick_opcode(OP_SBC), 8'h00);
  endtask

  task automatic test_logic_compare();
    send_instr(pick_opcode(OP_ORA), 8'h80);
    send_instr(pick_opcode(OP_AND), 8'h7f);
    send_instr(pick_opcode(OP_EOR), 8'hff);
    send_instr(pick_opcode(OP_CMP), 8'hff);
    send_instr(pick_opcode(OP_CPX), 8'h00);
    send_instr(pick_opcode(OP_CPY), 8'h80);
    send_instr(pick_opcode(OP_BIT), 8'hc0);
  endtask

  // Each shift kind on A and on memory, with carry in both states.
  task automatic test_shifts_and_rmw();
    send_instr(pick_opcode(OP_SEC), 8'h00);
    send_instr(pick_opcode(OP_SHIFT_A, SH_ROR), 8'h00);
    send_instr(pick_opcode(OP_SHIFT_A, SH_ROL), 8'h00);
    send_instr(pick_opcode(OP_SHIFT_A, SH_ASL), 8'h00);
    send_instr(pick_opcode(OP_SHIFT_A, SH_LSR), 8'h00);
    send_instr(pick_opcode(OP_SHIFT_M, SH_ASL), 8'h80);
    send_instr(pick_opcode(OP_SHIFT_M, SH_ROL), 8'hff);
    send_instr(pick_opcode(OP_SHIFT_M, SH_LSR), 8'h01);
    send_instr(pick_opcode(OP_SHIFT_M, SH_ROR), 8'h01);
    send_instr(pick_opcode(OP_INC_M), 8'hff);
    send_instr(pick_opcode(OP_DEC_M), 8'h00);
  endtask

  task automatic test_flag_ops();
    send_instr(pick_opcode(OP_SEI), 8'h00);
    send_instr(pick_opcode(OP_CLV), 8'h00);
    send_instr(pick_opcode(OP_CLC), 8'h00);
    send_instr(pick_opcode(OP_CLD), 8'h00);
    send_instr(pick_opcode(OP_CLI), 8'h00);
  endtask

  // Undefined and out-of-scope opcodes must leave everything alone.
  task automatic test_unused_opcodes();
    send_instr(pick_opcode(OP_LDA), 8'hc3);
    send_instr(pick_opcode(OP_SEC), 8'h00);
    send_instr(OpcNopImm, 8'hff);
    send_instr(OpcSbcAlias, 8'h01);
    send_instr(OpcBrk, 8'h00);
    send_instr(OpcJmp, 8'h80);
    send_instr(OpcPha, 8'h7f);
    send_instr(OpcBpl, 8'hff);
  endtask

  // Mostly defined data-path ops with corner-heavy operands; a fifth of the
  // beats are any opcode byte at all.
  task automatic test_random_stream(input int unsigned count);
    logic [7:0] opc;
    repeat (count) begin
      if ($urandom_range(0, 4) == 0)
        opc = 8'($urandom_range(0, 255));
      else
        opc = pick_opcode(op_e'($urandom_range(int'(OP_ORA), int'(OP_SED))),
                          shift_e'($urandom_range(0, 3)));
      send_instr(opc, pick_operand());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tuser  = 8'h00;
    cpu_state     = '0;
    cpu_state.sp  = SpReset;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_values();
    test_loads_stores();
    test_transfers_and_steps();
    test_arith();
    test_logic_compare();
    test_shifts_and_rmw();
    test_flag_ops();
    test_unused_opcodes();

    test_random_stream(500);
    wait_drained();            // hold input until the pipe is empty
    no_idle = 1'b1;            // back-to-back on both sides
    test_random_stream(250);
    no_idle = 1'b0;
    test_random_stream(450);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatches++;
    end

    $display("Ran %0d instructions (all data ops, unused opcodes, random mix).",
             items_sent);
    $display("Checked %0d result beats, %0d field mismatches.", beats_seen, mismatches);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout with %0d results outstanding.", pending_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
